FILE: design/tlsa_pkg.sv
// Package for the thumb logic and shift alu.
// Holds the word width, the operation codes and the result bundle type.
// No dependencies.
package tlsa_pkg;

	localparam int WORD_WIDTH = 32;
	localparam int AMT_WIDTH  = 8;
	localparam int SH_WIDTH   = 5;

	typedef logic [WORD_WIDTH-1:0] word_t;

	// operation codes carried on the mode port
	typedef enum logic [3:0] {
		OP_AND     = 4'd0,
		OP_ASR_IMM = 4'd1,
		OP_ASR_REG = 4'd2,
		OP_BIC     = 4'd3,
		OP_EOR     = 4'd4,
		OP_LSL_IMM = 4'd5,
		OP_LSL_REG = 4'd6,
		OP_LSR_IMM = 4'd7,
		OP_LSR_REG = 4'd8,
		OP_NEG     = 4'd9,
		OP_ORR     = 4'd10,
		OP_ROR_REG = 4'd11,
		OP_TST     = 4'd12
	} op_t;

	localparam word_t MIN_NEG_WORD = {1'b1, {(WORD_WIDTH-1){1'b0}}};

	// one finished result with its flags
	typedef struct packed {
		word_t value;
		logic  write_enable;
		logic  negative;
		logic  zero;
		logic  carry;
		logic  overflow;
	} tlsa_result_t;

endpackage

FILE: design/tlsa_core.sv
// Combinational datapath of the thumb logic and shift alu: logic ops,
// barrel shifts by immediate and by register, negate, and flag generation.
// Depends on tlsa_pkg.
module tlsa_core
	import tlsa_pkg::*;
(
	input  logic [3:0]          mode,
	input  word_t               dest_value,
	input  word_t               second_value,
	input  logic [SH_WIDTH-1:0] shift_immediate,
	input  logic                carry_in,
	input  logic                overflow_in,
	output tlsa_result_t        result
);

	logic [AMT_WIDTH-1:0]  amt;
	logic [SH_WIDTH-1:0]   amt_lo;
	logic                  amt_zero;
	logic                  amt_big;
	logic                  amt_is_width;
	logic [SH_WIDTH-1:0]   imm_m1;
	logic [SH_WIDTH-1:0]   amt_m1;
	logic [2*WORD_WIDTH-1:0] rot_w;
	word_t                 res;
	logic                  we;
	logic                  c;
	logic                  v;

	// register shift amount decode from the low byte of rs
	assign amt          = second_value[AMT_WIDTH-1:0];
	assign amt_lo       = amt[SH_WIDTH-1:0];
	assign amt_zero     = (amt == '0);
	assign amt_big      = |amt[AMT_WIDTH-1:SH_WIDTH];
	assign amt_is_width = (amt == AMT_WIDTH'(WORD_WIDTH));
	assign imm_m1       = shift_immediate - SH_WIDTH'(1);
	assign amt_m1       = amt_lo - SH_WIDTH'(1);
	assign rot_w        = {dest_value, dest_value} >> amt_lo;

	// operation select
	always_comb begin
		res = dest_value;
		we  = 1'b1;
		c   = carry_in;
		v   = overflow_in;
		case (mode)
			OP_AND: begin
				res = dest_value & second_value;
			end
			OP_ASR_IMM: begin
				if (shift_immediate == '0) begin
					c   = second_value[WORD_WIDTH-1];
					res = {WORD_WIDTH{second_value[WORD_WIDTH-1]}};
				end else begin
					c   = second_value[imm_m1];
					res = word_t'($signed(second_value) >>> shift_immediate);
				end
			end
			OP_ASR_REG: begin
				if (amt_zero) begin
					res = dest_value;
				end else if (!amt_big) begin
					c   = dest_value[amt_m1];
					res = word_t'($signed(dest_value) >>> amt_lo);
				end else begin
					c   = dest_value[WORD_WIDTH-1];
					res = {WORD_WIDTH{dest_value[WORD_WIDTH-1]}};
				end
			end
			OP_BIC: begin
				res = dest_value & ~second_value;
			end
			OP_EOR: begin
				res = dest_value ^ second_value;
			end
			OP_LSL_IMM: begin
				if (shift_immediate == '0) begin
					res = second_value;
				end else begin
					// bit index is width minus the amount, taken modulo the width
					c   = second_value[SH_WIDTH'(0) - shift_immediate];
					res = second_value << shift_immediate;
				end
			end
			OP_LSL_REG: begin
				if (amt_zero) begin
					res = dest_value;
				end else if (!amt_big) begin
					c   = dest_value[SH_WIDTH'(0) - amt_lo];
					res = dest_value << amt_lo;
				end else if (amt_is_width) begin
					c   = dest_value[0];
					res = '0;
				end else begin
					c   = 1'b0;
					res = '0;
				end
			end
			OP_LSR_IMM: begin
				if (shift_immediate == '0) begin
					c   = second_value[WORD_WIDTH-1];
					res = '0;
				end else begin
					c   = second_value[imm_m1];
					res = second_value >> shift_immediate;
				end
			end
			OP_LSR_REG: begin
				if (amt_zero) begin
					res = dest_value;
				end else if (!amt_big) begin
					c   = dest_value[amt_m1];
					res = dest_value >> amt_lo;
				end else if (amt_is_width) begin
					c   = dest_value[WORD_WIDTH-1];
					res = '0;
				end else begin
					c   = 1'b0;
					res = '0;
				end
			end
			OP_NEG: begin
				res = '0 - second_value;
				c   = (second_value == '0);
				v   = (second_value == MIN_NEG_WORD);
			end
			OP_ORR: begin
				res = dest_value | second_value;
			end
			OP_ROR_REG: begin
				if (amt_zero) begin
					res = dest_value;
				end else if (amt_lo == '0) begin
					c   = dest_value[WORD_WIDTH-1];
					res = dest_value;
				end else begin
					c   = dest_value[amt_m1];
					res = rot_w[WORD_WIDTH-1:0];
				end
			end
			OP_TST: begin
				res = dest_value & second_value;
				we  = 1'b0;
			end
			default: begin
				// unused codes: no operation, destination untouched
				res = dest_value;
				we  = 1'b0;
			end
		endcase
	end

	// pack result and flags
	assign result.value        = res;
	assign result.write_enable = we;
	assign result.negative     = res[WORD_WIDTH-1];
	assign result.zero         = (res == '0);
	assign result.carry        = c;
	assign result.overflow     = v;

endmodule

FILE: design/thumb_logic_shift_alu.sv
// Top level of the thumb logic and shift alu: input register, datapath,
// result register with done strobe.
// Depends on tlsa_pkg and tlsa_core.

// One instruction is taken at every clock edge where start is high; busy is
// always low, so commands may be issued back to back. Each command gives one
// result after the input register and then the result register, shown with
// done high for exactly one cycle. There is no way to stall the result side,
// so the receiver must take every result in the cycle done is high. The rate
// is one instruction per cycle, set by the single pass through the logic unit
// and barrel shifter between the input register and the result register.
module thumb_logic_shift_alu
	import tlsa_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [3:0]          mode,
	input  word_t               dest_value,
	input  word_t               second_value,
	input  logic [SH_WIDTH-1:0] shift_immediate,
	input  logic                carry_in,
	input  logic                overflow_in,
	output logic                done,
	output word_t               result_value,
	output logic                write_enable,
	output logic                negative_flag,
	output logic                zero_flag,
	output logic                carry_flag,
	output logic                overflow_flag
);

	logic                valid_s1;
	logic [3:0]          mode_s1;
	word_t               dest_s1;
	word_t               second_s1;
	logic [SH_WIDTH-1:0] imm_s1;
	logic                carry_s1;
	logic                overflow_s1;
	tlsa_result_t        result_c;
	logic                done_s2;
	tlsa_result_t        result_s2;
	logic                accept;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1     <= mode;
			dest_s1     <= dest_value;
			second_s1   <= second_value;
			imm_s1      <= shift_immediate;
			carry_s1    <= carry_in;
			overflow_s1 <= overflow_in;
		end
	end

	// logic and shift datapath
	tlsa_core u_core (
		.mode            (mode_s1),
		.dest_value      (dest_s1),
		.second_value    (second_s1),
		.shift_immediate (imm_s1),
		.carry_in        (carry_s1),
		.overflow_in     (overflow_s1),
		.result          (result_c)
	);

	// result stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= valid_s1;
		end
	end

	// result stage payload
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_s2 <= result_c;
		end
	end

	// result ports
	assign done          = done_s2;
	assign result_value  = result_s2.value;
	assign write_enable  = result_s2.write_enable;
	assign negative_flag = result_s2.negative;
	assign zero_flag     = result_s2.zero;
	assign carry_flag    = result_s2.carry;
	assign overflow_flag = result_s2.overflow;

endmodule
